### hdl/tect_pkg.sv
// tect_pkg: shared constants and codes for the threshold error counter table.
// No dependencies; imported by the unit, the checker and the bench.
`default_nettype none

package tect_pkg;

   // default sizes of the table
   localparam int DEF_MAX_GROUPS    = 4;
   localparam int DEF_MAX_INSTANCES = 16;
   localparam int DEF_COUNT_WIDTH   = 12;

   // fixed field widths of the register and item words
   localparam int NUM_PACKED  = 4;
   localparam int LIMIT_W     = 5;
   localparam int GROUPS_W    = 3;
   localparam int LIMITS_W    = NUM_PACKED * LIMIT_W;
   localparam int THRESH_W    = 48;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = THRESH_W;

   localparam logic [GROUPS_W-1:0] GROUPS_RESET = 3'd4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUPS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMITS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLDS = 2'd2;

   // opcodes (the unused code behaves as a query)
   localparam logic [1:0] OP_COUNT = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // return codes
   localparam logic [1:0] RC_OK           = 2'd0;
   localparam logic [1:0] RC_EXPIRED      = 2'd1;
   localparam logic [1:0] RC_BAD_GROUP    = 2'd2;
   localparam logic [1:0] RC_BAD_INSTANCE = 2'd3;

   // entry status
   localparam logic [1:0] ST_UNSET   = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;
   localparam logic [1:0] ST_EXPIRED = 2'd2;

endpackage

`default_nettype wire

### hdl/tect_ram.sv
// tect_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none

module tect_ram #(
   parameter int WIDTH      = 13,
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/threshold_error_counter_table_unit.sv
// Threshold error counter table: top level.
// Depends on tect_pkg and tect_ram.
//
//   channel   ports                                   handshake
//   request   start, busy, req_opcode/group/instance   start & !busy
//   response  rsp_strobe, rsp_*                       strobe, one cycle, no stall
//   csr       csr_valid, csr_ready, csr_index/wdata   valid & ready
//
// One word accepted per cycle; busy stays low. After acceptance the result passes
// the registered table read (stage 1) and then the registered update.
// A write to the entry read in the same cycle is forwarded from a bypass register.
// Synchronous reset clears the valid bits of all entries at once (entries that
// are not valid read as zero), the expired latch and the pipeline.
// The receiver cannot stall; results are never held back.
`default_nettype none

module threshold_error_counter_table_unit import tect_pkg::*; #(
   parameter int MAX_GROUPS    = DEF_MAX_GROUPS,
   parameter int MAX_INSTANCES = DEF_MAX_INSTANCES,
   parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             req_opcode,
   input  wire logic [3:0]             req_group_index,
   input  wire logic [4:0]             req_instance_index,
   // response
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_return_code,
   output logic [1:0]                  rsp_entry_status,
   output logic                        rsp_expired_flag,
   output logic [1:0]                  rsp_expired_group,
   output logic [3:0]                  rsp_expired_instance,
   // configuration
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TABLE_DEPTH = MAX_GROUPS * MAX_INSTANCES;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ENTRY_W     = COUNT_WIDTH + 1;
   localparam int EXT_W       = THRESH_W + NUM_PACKED * COUNT_WIDTH;

   // configuration registers
   logic [GROUPS_W-1:0] groups_ff;
   logic [LIMITS_W-1:0] limits_ff;
   logic [THRESH_W-1:0] thresholds_ff;

   // address decode
   logic                   accept;
   logic [EXT_W-1:0]       thr_ext;
   logic [LIMIT_W-1:0]     dec_lim;
   logic [COUNT_WIDTH-1:0] dec_thr;
   logic                   dec_gvalid;
   logic                   dec_ivalid;
   logic [9:0]             dec_idx_full;
   logic [IDX_W-1:0]       dec_idx;

   // stage 1
   logic                   s1_vld_ff;
   logic [1:0]             s1_op_ff;
   logic [1:0]             s1_group_ff;
   logic [3:0]             s1_inst_ff;
   logic                   s1_gvalid_ff;
   logic                   s1_ivalid_ff;
   logic [IDX_W-1:0]       s1_idx_ff;
   logic [COUNT_WIDTH-1:0] s1_thr_ff;
   logic                   vbit_rd_ff;

   // table state
   logic [TABLE_DEPTH-1:0] vbit_ff;
   logic [ENTRY_W-1:0]     ram_rdata;
   logic                   fwd_vld_ff;
   logic [IDX_W-1:0]       fwd_idx_ff;
   logic [ENTRY_W-1:0]     fwd_data_ff;

   // update
   logic [ENTRY_W-1:0]     cur_entry;
   logic [COUNT_WIDTH:0]   cnt_inc;
   logic [ENTRY_W-1:0]     new_entry;
   logic                   wr_en;
   logic                   is_mod;
   logic [1:0]             rc_in;
   logic [1:0]             status_in;

   // expired latch and response
   logic       latch_ff,  latch_in;
   logic [1:0] lgroup_ff, lgroup_in;
   logic [3:0] linst_ff,  linst_in;
   logic       rsp_strobe_ff;
   logic [1:0] rsp_rc_ff;
   logic [1:0] rsp_status_ff;
   logic       rsp_flag_ff;
   logic [1:0] rsp_group_ff;
   logic [3:0] rsp_inst_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // ---------------- decode of the incoming word ----------------
   assign thr_ext = {{(NUM_PACKED * COUNT_WIDTH){1'b0}}, thresholds_ff};

   always_comb begin
      dec_lim = '0;
      dec_thr = '0;
      for (int k = 0; k < NUM_PACKED; k++) begin
         if (req_group_index == 4'(k)) begin
            dec_lim = limits_ff[k*LIMIT_W +: LIMIT_W];
            dec_thr = thr_ext[k*COUNT_WIDTH +: COUNT_WIDTH];
         end
      end
      if (dec_lim > LIMIT_W'(MAX_INSTANCES)) begin
         dec_lim = LIMIT_W'(MAX_INSTANCES);
      end
   end

   assign dec_gvalid = ({1'b0, req_group_index} < {2'b00, groups_ff}) &&
                       ({1'b0, req_group_index} < 5'(MAX_GROUPS));
   assign dec_ivalid = dec_gvalid && (req_instance_index < dec_lim);
   assign dec_idx_full = 10'(req_group_index) * 10'(MAX_INSTANCES) +
                         10'(req_instance_index);
   assign dec_idx = dec_ivalid ? dec_idx_full[IDX_W-1:0] : '0;

   tect_ram #(
      .WIDTH      (ENTRY_W),
      .DEPTH      (TABLE_DEPTH),
      .ADDR_WIDTH (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (new_entry),
      .rd_en   (accept),
      .rd_addr (dec_idx),
      .rd_data (ram_rdata)
   );

   // ---------------- update of the addressed entry ----------------
   // a write at the edge of our read is not seen by the RAM; take the bypass
   always_comb begin
      if (fwd_vld_ff && fwd_idx_ff == s1_idx_ff) begin
         cur_entry = fwd_data_ff;
      end else if (vbit_rd_ff) begin
         cur_entry = ram_rdata;
      end else begin
         cur_entry = '0;
      end
   end

   assign cnt_inc = {1'b0, cur_entry[COUNT_WIDTH-1:0]} + 1'b1;
   assign is_mod  = s1_op_ff inside {OP_COUNT, OP_CLEAR};

   always_comb begin
      rc_in     = RC_OK;
      new_entry = cur_entry;
      wr_en     = 1'b0;
      latch_in  = latch_ff;
      lgroup_in = lgroup_ff;
      linst_in  = linst_ff;
      if (is_mod && latch_ff) begin
         rc_in = RC_EXPIRED;
      end else if (!s1_gvalid_ff) begin
         rc_in = RC_BAD_GROUP;
      end else if (!s1_ivalid_ff) begin
         rc_in = RC_BAD_INSTANCE;
      end else begin
         case (s1_op_ff)
            OP_COUNT: begin
               wr_en = s1_vld_ff;
               if (cnt_inc >= {1'b0, s1_thr_ff}) begin
                  // expired: marker bit, count parked at zero
                  new_entry = {1'b1, {COUNT_WIDTH{1'b0}}};
                  latch_in  = s1_vld_ff | latch_ff;
                  if (s1_vld_ff) begin
                     lgroup_in = s1_group_ff;
                     linst_in  = s1_inst_ff;
                  end
               end else begin
                  new_entry = {1'b0, cnt_inc[COUNT_WIDTH-1:0]};
               end
            end
            OP_CLEAR: begin
               wr_en     = s1_vld_ff;
               new_entry = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // status after the step; a lowered threshold reads a running count as expired
   always_comb begin
      if (!s1_ivalid_ff) begin
         status_in = ST_UNSET;
      end else if (new_entry[COUNT_WIDTH]) begin
         status_in = ST_EXPIRED;
      end else if (new_entry[COUNT_WIDTH-1:0] == '0) begin
         status_in = ST_UNSET;
      end else if (new_entry[COUNT_WIDTH-1:0] >= s1_thr_ff) begin
         status_in = ST_EXPIRED;
      end else begin
         status_in = ST_RUNNING;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff     <= GROUPS_RESET;
         limits_ff     <= '0;
         thresholds_ff <= '0;
         s1_vld_ff     <= 1'b0;
         vbit_ff       <= '0;
         fwd_vld_ff    <= 1'b0;
         latch_ff      <= 1'b0;
         lgroup_ff     <= '0;
         linst_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GROUPS:     groups_ff     <= csr_wdata[GROUPS_W-1:0];
               CSR_LIMITS:     limits_ff     <= csr_wdata[LIMITS_W-1:0];
               CSR_THRESHOLDS: thresholds_ff <= csr_wdata[THRESH_W-1:0];
               default: begin
               end
            endcase
         end
         s1_vld_ff <= accept;
         if (wr_en) begin
            vbit_ff[s1_idx_ff] <= 1'b1;
         end
         fwd_vld_ff    <= wr_en;
         latch_ff      <= latch_in;
         lgroup_ff     <= lgroup_in;
         linst_ff      <= linst_in;
         rsp_strobe_ff <= s1_vld_ff;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= req_opcode;
         s1_group_ff  <= req_group_index[1:0];
         s1_inst_ff   <= req_instance_index[3:0];
         s1_gvalid_ff <= dec_gvalid;
         s1_ivalid_ff <= dec_ivalid;
         s1_idx_ff    <= dec_idx;
         s1_thr_ff    <= dec_thr;
         vbit_rd_ff   <= vbit_ff[dec_idx];
      end
      if (wr_en) begin
         fwd_idx_ff  <= s1_idx_ff;
         fwd_data_ff <= new_entry;
      end
      rsp_rc_ff     <= rc_in;
      rsp_status_ff <= status_in;
      rsp_flag_ff   <= latch_in;
      rsp_group_ff  <= lgroup_in;
      rsp_inst_ff   <= linst_in;
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_return_code      = rsp_rc_ff;
   assign rsp_entry_status     = rsp_status_ff;
   assign rsp_expired_flag     = rsp_flag_ff;
   assign rsp_expired_group    = rsp_group_ff;
   assign rsp_expired_instance = rsp_inst_ff;

endmodule

`default_nettype wire

### hdl/tect_checker.sv
// tect_checker: port-level assertions for the threshold error counter table,
// bound to the top level. Depends on tect_pkg.
`default_nettype none

module tect_checker import tect_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_strobe,
   input wire logic [1:0]             rsp_return_code,
   input wire logic [1:0]             rsp_entry_status,
   input wire logic                   rsp_expired_flag,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready
);

   // every accepted word is answered by a response strobe
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted word without response");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without accepted word");

   // refusal for expiry only while the sticky flag is up
   a_refused_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_return_code == RC_EXPIRED) |-> rsp_expired_flag)
      else $error("expired refusal with flag low");

   // a bad address never reports a live entry
   a_bad_addr_unset: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_return_code == RC_BAD_GROUP ||
                      rsp_return_code == RC_BAD_INSTANCE))
      |-> rsp_entry_status == ST_UNSET)
      else $error("bad address with non-unset status");

   // register writes are never held off
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write held off");

endmodule

bind threshold_error_counter_table_unit tect_checker u_tect_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_return_code  (rsp_return_code),
   .rsp_entry_status (rsp_entry_status),
   .rsp_expired_flag (rsp_expired_flag),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready)
);

`default_nettype wire

### bench/threshold_error_counter_table_unit_test.sv
// Self-checking bench for threshold_error_counter_table_unit.
// Keeps a mirror of the counter table, thresholds and expiry latch, and checks every response.
// Depends on tect_pkg and the unit under test.
`timescale 1ns / 100ps

module threshold_error_counter_table_unit_test;
   import tect_pkg::*;

   localparam int TABLE_GROUPS    = DEF_MAX_GROUPS;
   localparam int TABLE_INSTANCES = DEF_MAX_INSTANCES;
   localparam int COUNT_W         = DEF_COUNT_WIDTH;
   localparam int TABLE_ENTRIES   = TABLE_GROUPS * TABLE_INSTANCES;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam realtime CLOCK_PERIOD = 12.0;
   localparam int unsigned TIMEOUT_CYCLES = 400000;
   localparam logic [LIMITS_W-1:0] ALL_LIMITS_MAX = '1;
   localparam logic [THRESH_W-1:0] ALL_THRESH_MAX = '1;

   typedef struct packed {
      logic [1:0] return_code;
      logic [1:0] entry_status;
      logic       expired_flag;
      logic [1:0] expired_group;
      logic [3:0] expired_instance;
   } table_response_type;

   class error_table_mirror_type;
      logic [COUNT_W-1:0]  counts [TABLE_ENTRIES];
      bit                  expired [TABLE_ENTRIES];
      logic [GROUPS_W-1:0] groups;
      logic [LIMITS_W-1:0] limits;
      logic [THRESH_W-1:0] thresholds;
      bit                  latch;
      logic [1:0]          latched_group;
      logic [3:0]          latched_instance;
      table_response_type  awaited_responses [$];
      int                  errors;
      int                  checked;
      int                  refused;
      int                  op_seen [4];

      function new();
         foreach (counts[n]) begin
            counts[n] = '0;
            expired[n] = 1'b0;
         end
         groups = GROUPS_RESET;
         limits = '0;
         thresholds = '0;
         latch = 1'b0;
         latched_group = '0;
         latched_instance = '0;
         errors = 0;
         checked = 0;
         refused = 0;
         foreach (op_seen[n]) op_seen[n] = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_GROUPS:     groups = data[GROUPS_W-1:0];
            CSR_LIMITS:     limits = data[LIMITS_W-1:0];
            CSR_THRESHOLDS: thresholds = data[THRESH_W-1:0];
            default: ;
         endcase
      endfunction

      // limits above the instance count saturate
      function int limit_of(logic [3:0] g);
         logic [LIMITS_W-1:0] sh;
         if (g >= NUM_PACKED) return 0;
         sh = limits >> (LIMIT_W * g);
         return (sh[LIMIT_W-1:0] > TABLE_INSTANCES) ? TABLE_INSTANCES : int'(sh[LIMIT_W-1:0]);
      endfunction

      function int threshold_of(logic [3:0] g);
         logic [THRESH_W-1:0] sh;
         if (g >= NUM_PACKED) return 0;
         sh = thresholds >> (COUNT_W * g);
         return int'(sh[COUNT_W-1:0]);
      endfunction

      function bit address_ok(logic [3:0] g, logic [4:0] inst);
         return (g < groups) && (g < TABLE_GROUPS) && (inst < limit_of(g));
      endfunction

      function bit would_expire(logic [1:0] op, logic [3:0] g, logic [4:0] inst);
         if (op != OP_COUNT || latch || !address_ok(g, inst)) return 1'b0;
         return int'(counts[g * TABLE_INSTANCES + inst]) + 1 >= threshold_of(g);
      endfunction

      function void apply_request(logic [1:0] op, logic [3:0] g, logic [4:0] inst);
         table_response_type r;
         bit group_ok;
         bit inst_ok;
         int idx;
         int thr;
         group_ok = (g < groups) && (g < TABLE_GROUPS);
         inst_ok = address_ok(g, inst);
         idx = inst_ok ? g * TABLE_INSTANCES + inst : 0;
         thr = threshold_of(g);
         r = '0;
         op_seen[op]++;
         if ((op inside {OP_COUNT, OP_CLEAR}) && latch) begin
            r.return_code = RC_EXPIRED;
            refused++;
         end else if (!group_ok) begin
            r.return_code = RC_BAD_GROUP;
         end else if (!inst_ok) begin
            r.return_code = RC_BAD_INSTANCE;
         end else begin
            r.return_code = RC_OK;
            if (op == OP_COUNT) begin
               if (int'(counts[idx]) + 1 >= thr) begin
                  expired[idx] = 1'b1;
                  counts[idx] = '0;
                  latch = 1'b1;
                  latched_group = g[1:0];
                  latched_instance = inst[3:0];
               end else begin
                  counts[idx] = counts[idx] + 1'b1;
               end
            end else if (op == OP_CLEAR) begin
               counts[idx] = '0;
               expired[idx] = 1'b0;
            end
         end
         if (!inst_ok)                    r.entry_status = ST_UNSET;
         else if (expired[idx])           r.entry_status = ST_EXPIRED;
         else if (counts[idx] == 0)       r.entry_status = ST_UNSET;
         else if (int'(counts[idx]) >= thr) r.entry_status = ST_EXPIRED;
         else                             r.entry_status = ST_RUNNING;
         r.expired_flag = latch;
         r.expired_group = latched_group;
         r.expired_instance = latched_instance;
         awaited_responses.push_back(r);
      endfunction

      function void compare_field(string name, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(table_response_type got);
         table_response_type want;
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = awaited_responses.pop_front();
         checked++;
         compare_field("return_code", 4'(want.return_code), 4'(got.return_code));
         compare_field("entry_status", 4'(want.entry_status), 4'(got.entry_status));
         compare_field("expired_flag", 4'(want.expired_flag), 4'(got.expired_flag));
         compare_field("expired_group", 4'(want.expired_group), 4'(got.expired_group));
         compare_field("expired_instance", want.expired_instance, got.expired_instance);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_opcode = '0;
   logic [3:0] req_group_index = '0;
   logic [4:0] req_instance_index = '0;
   logic rsp_strobe;
   logic [1:0] rsp_return_code;
   logic [1:0] rsp_entry_status;
   logic rsp_expired_flag;
   logic [1:0] rsp_expired_group;
   logic [3:0] rsp_expired_instance;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   error_table_mirror_type mirror;
   bit no_gaps = 1'b0;

   threshold_error_counter_table_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_group_index(req_group_index),
      .req_instance_index(req_instance_index),
      .rsp_strobe(rsp_strobe),
      .rsp_return_code(rsp_return_code),
      .rsp_entry_status(rsp_entry_status),
      .rsp_expired_flag(rsp_expired_flag),
      .rsp_expired_group(rsp_expired_group),
      .rsp_expired_instance(rsp_expired_instance),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // pre-edge values: the block updates with nonblocking assignments
   always @(posedge clock) begin
      if (!reset && start && !busy)
         mirror.apply_request(req_opcode, req_group_index, req_instance_index);
      if (!reset && csr_valid && csr_ready)
         mirror.write_register(csr_index, csr_wdata);
      if (!reset && rsp_strobe)
         mirror.check_response({rsp_return_code, rsp_entry_status, rsp_expired_flag,
                                rsp_expired_group, rsp_expired_instance});
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called and returns just after a falling edge
   task automatic send_request(input logic [1:0] op, input logic [3:0] g, input logic [4:0] inst);
      int gap;
      start <= 1'b1;
      req_opcode <= op;
      req_group_index <= g;
      req_instance_index <= inst;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      gap = gap_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // registers change only with no word in flight
   task automatic write_register_word(input logic [CSR_INDEX_W-1:0] index,
                                      input logic [CSR_DATA_W-1:0] data);
      start <= 1'b0;
      while (mirror.awaited_responses.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_config();
      logic [LIMITS_W-1:0] lim_word;
      logic [THRESH_W-1:0] thr_word;
      int pick;
      int n;
      pick = $urandom_range(0, 9);
      write_register_word(CSR_GROUPS,
                          CSR_DATA_W'((pick == 0) ? 0 : (pick < 4) ? $urandom_range(1, 3) : 4));
      for (n = 0; n < NUM_PACKED; n++) begin
         pick = $urandom_range(0, 9);
         lim_word[n*LIMIT_W +: LIMIT_W] =
            LIMIT_W'((pick == 0) ? 0 : (pick < 3) ? $urandom_range(17, 31) :
                     (pick == 3) ? TABLE_INSTANCES : $urandom_range(1, 15));
         pick = $urandom_range(0, 9);
         thr_word[n*COUNT_W +: COUNT_W] =
            COUNT_W'((pick == 0) ? 0 : (pick < 3) ? $urandom_range(0, 4095) :
                     (pick == 3) ? 4095 : $urandom_range(1, 12));
      end
      write_register_word(CSR_LIMITS, CSR_DATA_W'(lim_word));
      write_register_word(CSR_THRESHOLDS, thr_word);
   endtask

   // with hold_latch set, a count that would expire an entry becomes a query,
   // so the one-shot expiry latch stays low until the closing phase
   task automatic run_random(input int items, input bit hold_latch);
      logic [1:0] op;
      logic [3:0] g;
      logic [4:0] inst;
      int lim;
      int span;
      int pick;
      int k;
      for (k = 0; k < items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)      op = OP_COUNT;
         else if (pick < 62) op = OP_CLEAR;
         else if (pick < 92) op = OP_QUERY;
         else                op = OP_SPARE;
         if (mirror.groups != 0 && $urandom_range(0, 99) < 85)
            g = 4'($urandom_range(0, ((mirror.groups > TABLE_GROUPS) ? TABLE_GROUPS :
                                      mirror.groups) - 1));
         else
            g = 4'($urandom_range(0, 15));
         lim = mirror.limit_of(g);
         if (lim != 0 && $urandom_range(0, 99) < 88) begin
            // a few hot entries so counts climb towards their thresholds
            span = (lim > 3 && $urandom_range(0, 1)) ? 3 : lim;
            inst = 5'($urandom_range(0, span - 1));
         end else begin
            inst = 5'($urandom_range(0, 31));
         end
         if (hold_latch && mirror.would_expire(op, g, inst)) op = OP_QUERY;
         send_request(op, g, inst);
      end
   endtask

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [THRESH_W-1:0] thr_word;
      logic [3:0] pick_group;
      logic [4:0] pick_inst;
      int phase;
      int waited;
      mirror = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: every instance limit is zero
      send_request(OP_QUERY, 4'd0, 5'd0);
      send_request(OP_COUNT, 4'd0, 5'd0);
      send_request(OP_CLEAR, 4'd3, 5'd15);
      send_request(OP_QUERY, 4'd4, 5'd0);
      send_request(OP_COUNT, 4'd15, 5'd31);
      send_request(OP_SPARE, 4'd0, 5'd0);

      write_register_word(CSR_GROUPS, CSR_DATA_W'(4));
      write_register_word(CSR_LIMITS, CSR_DATA_W'(ALL_LIMITS_MAX));
      write_register_word(CSR_THRESHOLDS, ALL_THRESH_MAX);
      send_request(OP_COUNT, 4'd0, 5'd0);
      send_request(OP_COUNT, 4'd0, 5'd0);
      send_request(OP_QUERY, 4'd0, 5'd0);
      send_request(OP_CLEAR, 4'd0, 5'd0);
      send_request(OP_COUNT, 4'd3, 5'd15);
      send_request(OP_QUERY, 4'd3, 5'd16);
      send_request(OP_COUNT, 4'd2, 5'd31);
      send_request(OP_SPARE, 4'd3, 5'd15);
      send_request(OP_CLEAR, 4'd7, 5'd5);
      repeat (3) send_request(OP_COUNT, 4'd1, 5'd2);

      // threshold dropped below a running count reads as expired
      write_register_word(CSR_THRESHOLDS, {12'hFFF, 12'hFFF, 12'd2, 12'hFFF});
      send_request(OP_QUERY, 4'd1, 5'd2);
      write_register_word(CSR_THRESHOLDS, {12'hFFF, 12'hFFF, 12'hFFF, 12'd0});
      send_request(OP_QUERY, 4'd0, 5'd1);
      write_register_word(CSR_GROUPS, CSR_DATA_W'(0));
      send_request(OP_QUERY, 4'd0, 5'd0);
      send_request(OP_CLEAR, 4'd1, 5'd2);

      for (phase = 0; phase < 6; phase++) begin
         random_config();
         no_gaps = (phase == 2);
         run_random(130, 1'b1);
      end
      no_gaps = 1'b0;

      // closing phase: lower a threshold onto a running count, then let it expire
      write_register_word(CSR_GROUPS, CSR_DATA_W'(4));
      write_register_word(CSR_LIMITS, CSR_DATA_W'(ALL_LIMITS_MAX));
      write_register_word(CSR_THRESHOLDS, ALL_THRESH_MAX);
      pick_group = 4'($urandom_range(0, TABLE_GROUPS - 1));
      pick_inst = 5'($urandom_range(0, TABLE_INSTANCES - 1));
      repeat ($urandom_range(1, 4)) send_request(OP_COUNT, pick_group, pick_inst);
      write_register_word(CSR_GROUPS, CSR_DATA_W'(4));
      thr_word = ALL_THRESH_MAX;
      thr_word[pick_group*COUNT_W +: COUNT_W] =
         mirror.counts[pick_group * TABLE_INSTANCES + pick_inst];
      write_register_word(CSR_THRESHOLDS, thr_word);
      send_request(OP_QUERY, pick_group, pick_inst);
      send_request(OP_COUNT, pick_group, pick_inst);
      send_request(OP_CLEAR, pick_group, pick_inst);
      send_request(OP_QUERY, pick_group, pick_inst);
      run_random(60, 1'b0);
      random_config();
      run_random(60, 1'b0);
      start <= 1'b0;

      waited = 0;
      while (mirror.awaited_responses.size() != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (mirror.awaited_responses.size() != 0) begin
         $display("%0t: %0d response words never arrived", $time,
                  mirror.awaited_responses.size());
         mirror.errors++;
      end

      $display("Checked %0d responses: %0d count, %0d clear, %0d query, %0d spare-opcode words.",
               mirror.checked, mirror.op_seen[OP_COUNT], mirror.op_seen[OP_CLEAR],
               mirror.op_seen[OP_QUERY], mirror.op_seen[OP_SPARE]);
      $display("Expiry latch raised: %0d, writes refused afterwards: %0d, mismatches: %0d.",
               mirror.latch, mirror.refused, mirror.errors);
      if (mirror.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
